### src/bitmap_node_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// bitmap node allocator assertion macros
// shared concurrent assertion forms for the allocator rtl
// ----------------------------------------------------------------------------
`ifndef BITMAP_NODE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_NODE_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BNA_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |-> (cons)) else $error("allocator assertion failed");

// next-cycle implication
`define BNA_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(resetn)) \
        (ante) |=> (cons)) else $error("allocator assertion failed");

`else

`define BNA_ASSERT_IMPLY(label, clock, resetn, ante, cons)
`define BNA_ASSERT_NEXT(label, clock, resetn, ante, cons)

`endif

`endif

### src/bna_pkg.sv
// ----------------------------------------------------------------------------
// bna_pkg
// types and constants of the bitmap node allocator
// ----------------------------------------------------------------------------
package bna_pkg;

    localparam int ENTRIES_DEF = 96;
    localparam int WORD_BITS   = 8;
    localparam int BIT_W       = $clog2(WORD_BITS);

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_MARK    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] handle_in;
        logic       mark_used;
    } in_item_t;

    typedef struct packed {
        logic [6:0] handle_out;
        logic [1:0] status;
        logic [6:0] free_count;
    } out_item_t;

endpackage

### src/bitmap_node_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_node_allocator_unit
// first-fit allocator over a used/free bitmap of file-system nodes
// ----------------------------------------------------------------------------
// The used/free map lives in a memory of 8-bit words, one read and one write
// port, with a valid bit per word so that reset and the clear command free
// every node at once. One command is taken at a time; in_ready is low while a
// command is in progress. Clear, allocate on a full map and a bad handle go from
// the input transfer straight to the response state; release and mark read one
// word, modify it and write it back; allocate examines one word of the map per
// cycle through the memory read port, from word 0 up to the word that holds the
// first free node. The result then waits in the output register and the next
// command can be taken in the cycle after it is loaded. Every result carries the
// free count after the command.
`include "bitmap_node_allocator_unit_assert.svh"

module bitmap_node_allocator_unit #(
    parameter int ENTRIES = bna_pkg::ENTRIES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bna_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bna_pkg::out_item_t   out_data
);
    import bna_pkg::*;

    localparam int WORDS     = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CMP_W     = (CNT_W > 7) ? CNT_W : 7;
    localparam int IDX_W     = (CNT_W > WA + BIT_W) ? CNT_W : WA + BIT_W;
    localparam int LAST_BITS = ENTRIES - (WORDS - 1) * WORD_BITS;
    // bits past the last node count as used during the search
    localparam logic [WORD_BITS-1:0] PAD_MASK = {WORD_BITS{1'b1}} << LAST_BITS;

    typedef enum logic [1:0] {S_IDLE, S_CHECK, S_RESP} state_t;

    state_t               state_reg, state_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [6:0]           handle_reg, handle_next;
    logic                 mark_reg, mark_next;
    logic [WA-1:0]        addr_reg, addr_next;
    logic [CNT_W-1:0]     free_total_reg, free_total_next;
    logic [WORDS-1:0]     word_valid_reg, word_valid_next;
    out_item_t            res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    logic [WORD_BITS-1:0] map_mem [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_valid_reg;
    logic [WA-1:0]        rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [WORD_BITS-1:0] word_cur;
    logic [WORD_BITS-1:0] search_word;
    logic                 found;
    logic [BIT_W-1:0]     first_bit;
    logic [6:0]           in_dec;
    logic [6:0]           h_dec;
    logic [BIT_W-1:0]     bit_sel;
    logic                 old_bit;
    logic                 new_bit;
    logic                 in_fire;
    logic                 handle_bad;
    logic [IDX_W-1:0]     alloc_idx;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_dec     = in_data.handle_in - 7'd1;
    assign handle_bad = (in_data.handle_in == 7'd0) ||
                        (CMP_W'(in_data.handle_in) > CMP_W'(ENTRIES));

    // examine unit: one map word per cycle
    assign word_cur    = rd_valid_reg ? rd_data_reg : '0;
    assign search_word = word_cur |
                         ((addr_reg == WA'(WORDS - 1)) ? PAD_MASK : '0);
    assign h_dec       = handle_reg - 7'd1;
    assign bit_sel     = h_dec[BIT_W-1:0];
    assign old_bit     = word_cur[bit_sel];
    assign new_bit     = (cmd_reg == CMD_RELEASE) ? 1'b0 : mark_reg;
    assign alloc_idx   = IDX_W'({addr_reg, first_bit});

    always_comb
    begin
        found     = 1'b0;
        first_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!search_word[b])
            begin
                found     = 1'b1;
                first_bit = BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        handle_next     = handle_reg;
        mark_next       = mark_reg;
        addr_next       = addr_reg;
        free_total_next = free_total_reg;
        word_valid_next = word_valid_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        rd_addr         = addr_reg;
        mem_we          = 1'b0;
        mem_wdata       = word_cur;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                rd_addr = (in_data.cmd == CMD_ALLOC) ? '0 : WA'(in_dec[6:BIT_W]);
                if (in_fire)
                begin
                    cmd_next    = in_data.cmd;
                    handle_next = in_data.handle_in;
                    mark_next   = in_data.mark_used;
                    addr_next   = rd_addr;
                    res_next.handle_out = '0;
                    res_next.status     = ST_OK;
                    res_next.free_count = 7'(free_total_reg);
                    state_next  = S_CHECK;
                    if (in_data.cmd == CMD_CLEAR)
                    begin
                        word_valid_next     = '0;
                        free_total_next     = CNT_W'(ENTRIES);
                        res_next.free_count = 7'(CNT_W'(ENTRIES));
                        state_next          = S_RESP;
                    end
                    else if (in_data.cmd == CMD_ALLOC)
                    begin
                        if (free_total_reg == '0)
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_RESP;
                        end
                    end
                    else if (handle_bad)
                    begin
                        res_next.status = ST_BADIDX;
                        state_next      = S_RESP;
                    end
                end
            end
            S_CHECK:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (found)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = word_cur | (WORD_BITS'(1) << first_bit);
                        word_valid_next[addr_reg] = 1'b1;
                        free_total_next     = free_total_reg - CNT_W'(1);
                        res_next.handle_out = 7'(alloc_idx + IDX_W'(1));
                        res_next.free_count = 7'(free_total_reg - CNT_W'(1));
                        state_next          = S_RESP;
                    end
                    else
                    begin
                        // keep the read port busy with the next word
                        rd_addr   = addr_reg + WA'(1);
                        addr_next = rd_addr;
                    end
                end
                else
                begin
                    mem_we              = 1'b1;
                    mem_wdata           = word_cur;
                    mem_wdata[bit_sel]  = new_bit;
                    word_valid_next[addr_reg] = 1'b1;
                    if (old_bit && !new_bit)
                    begin
                        free_total_next = free_total_reg + CNT_W'(1);
                    end
                    else if (!old_bit && new_bit)
                    begin
                        free_total_next = free_total_reg - CNT_W'(1);
                    end
                    res_next.free_count = 7'(free_total_next);
                    state_next          = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[addr_reg] <= mem_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_total_reg <= CNT_W'(ENTRIES);
            word_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_total_reg <= free_total_next;
            word_valid_reg <= word_valid_next;
            out_valid_reg  <= out_valid_next;
            rd_valid_reg   <= word_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        handle_reg   <= handle_next;
        mark_reg     <= mark_next;
        addr_reg     <= addr_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    `BNA_ASSERT_IMPLY(a_free_range, clk, rst_n, 1'b1, free_total_reg <= CNT_W'(ENTRIES))
    `BNA_ASSERT_IMPLY(a_scan_addr, clk, rst_n, state_reg == S_CHECK, addr_reg <= WA'(WORDS - 1))
    `BNA_ASSERT_NEXT(a_clear_count, clk, rst_n, in_fire && in_data.cmd == CMD_CLEAR, free_total_reg == CNT_W'(ENTRIES))
    `BNA_ASSERT_IMPLY(a_full_zero, clk, rst_n, out_valid_reg && out_data_reg.status == ST_FULL, out_data_reg.handle_out == 7'd0)

endmodule
